// ===== rtl/core/tagged_value_leb128_serializer_top_macros.svh =====
// Assertion macros for the tagged value LEB128 serializer.
// Depends on nothing; included by the top level.
`ifndef TAGGED_VALUE_LEB128_SERIALIZER_TOP_MACROS_SVH
`define TAGGED_VALUE_LEB128_SERIALIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TVLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TVLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tvls_pkg.sv =====
// Shared types and constants for the tagged value LEB128 serializer.
// No dependencies.
package tvls_pkg;

  localparam int NUM_CODES = 6;
  localparam int CFG_IDX_W = 3;
  localparam int RAW_CNT_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INT8    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INT16   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INT32   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT64   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLOAT32 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLOAT64 = 3'd5;

  localparam logic [7:0] CODE_RESET [NUM_CODES] = '{8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7};

  localparam logic [7:0] LEB_CONT_BIT = 8'h80;
  localparam int         LEB_GROUP_W  = 7;

  localparam logic [RAW_CNT_W-1:0] RAW_CNT_F32 = 4'd4;
  localparam logic [RAW_CNT_W-1:0] RAW_CNT_F64 = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAG,
    ST_LEB,
    ST_RAW
  } state_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_INT,
    KIND_RAW
  } kind_t;

endpackage

// ===== rtl/core/tagged_value_leb128_serializer_top.sv =====
// Top level of the tagged value LEB128 serializer.
// Depends on tvls_pkg and tagged_value_leb128_serializer_top_macros.svh.

// Each accepted request (tag in in_tuser, 64 payload bits in in_tdata) is
// turned into a stream of bytes on the out_ channel, one byte per beat, with
// out_tlast set on the final byte of the item. The tag byte always comes
// first. Integer tags emit the sign-extended value as signed LEB128 (1 to 10
// bytes), float tags emit 4 or 8 raw payload bytes low byte first, and an
// unknown tag emits only itself. The block takes one request at a time:
// after acceptance it moves to the tag state and then produces one byte per
// cycle while the sink keeps out_tready high; it takes no new request until
// the last byte of the item has been loaded into the output register. The
// pace is set by the single shift unit that peels off one 7-bit group or one
// raw byte per step, and by the output register, which the sink drains at
// its own pace. The tag codes are six 8-bit registers written through
// the cfg_ port (index 0 to 5: int8, int16, int32, int64, float32, float64);
// cfg_ready is always high, writes to indexes 6 and 7 are dropped, and a tag
// matching several codes takes the first in that order. Write the codes only
// while the block is idle.
module tagged_value_leb128_serializer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [63:0]                    in_tdata,   // [63:0] payload_bits
  input  logic [7:0]                     in_tuser,   // [7:0] type_tag
  // Result channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] out_byte
  output logic                           out_tlast,  // end_of_value
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tvls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

`include "tagged_value_leb128_serializer_top_macros.svh"

  // Tag code registers.
  logic [7:0] code_r [tvls_pkg::NUM_CODES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tvls_pkg::NUM_CODES; i++) begin
        code_r[i] <= tvls_pkg::CODE_RESET[i];
      end
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index < tvls_pkg::CFG_IDX_W'(tvls_pkg::NUM_CODES))) begin
      code_r[cfg_index] <= cfg_data;
    end
  end

  // Sequencer and shared shift unit state.
  tvls_pkg::state_t              state_r, state_nxt;
  tvls_pkg::kind_t               kind_r, kind_nxt;
  logic [7:0]                    tag_r, tag_nxt;
  logic [63:0]                   val_r, val_nxt;
  logic [tvls_pkg::RAW_CNT_W-1:0] cnt_r, cnt_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  logic in_acc;
  assign in_tready = (state_r == tvls_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // The output slot can take a byte when it is empty or being drained.
  logic step_en;
  assign step_en = !out_valid_r || out_tready;

  // Tag decode at acceptance: first matching code wins.
  tvls_pkg::kind_t                 dec_kind;
  logic [63:0]                     dec_val;
  logic [tvls_pkg::RAW_CNT_W-1:0]  dec_cnt;

  always_comb begin
    dec_kind = tvls_pkg::KIND_NONE;
    dec_val  = in_tdata;
    dec_cnt  = tvls_pkg::RAW_CNT_F64;
    if (in_tuser == code_r[tvls_pkg::REG_INT8]) begin
      dec_kind = tvls_pkg::KIND_INT;
      dec_val  = {{56{in_tdata[7]}}, in_tdata[7:0]};
    end else if (in_tuser == code_r[tvls_pkg::REG_INT16]) begin
      dec_kind = tvls_pkg::KIND_INT;
      dec_val  = {{48{in_tdata[15]}}, in_tdata[15:0]};
    end else if (in_tuser == code_r[tvls_pkg::REG_INT32]) begin
      dec_kind = tvls_pkg::KIND_INT;
      dec_val  = {{32{in_tdata[31]}}, in_tdata[31:0]};
    end else if (in_tuser == code_r[tvls_pkg::REG_INT64]) begin
      dec_kind = tvls_pkg::KIND_INT;
    end else if (in_tuser == code_r[tvls_pkg::REG_FLOAT32]) begin
      dec_kind = tvls_pkg::KIND_RAW;
      dec_cnt  = tvls_pkg::RAW_CNT_F32;
    end else if (in_tuser == code_r[tvls_pkg::REG_FLOAT64]) begin
      dec_kind = tvls_pkg::KIND_RAW;
    end
  end

  // Shared shift unit: one LEB128 group (arithmetic shift by 7) or one raw
  // byte (logical shift by 8) per step.
  logic [6:0]  leb_grp;
  logic [63:0] leb_rest;
  logic        leb_stop;

  assign leb_grp  = val_r[tvls_pkg::LEB_GROUP_W-1:0];
  assign leb_rest = {{tvls_pkg::LEB_GROUP_W{val_r[63]}}, val_r[63:tvls_pkg::LEB_GROUP_W]};
  assign leb_stop = ((leb_rest == '0) && !leb_grp[6]) || ((leb_rest == '1) && leb_grp[6]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tvls_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    tag_r      <= tag_nxt;
    val_r      <= val_nxt;
    cnt_r      <= cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    tag_nxt       = tag_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      tvls_pkg::ST_IDLE: begin
        if (in_acc) begin
          kind_nxt  = dec_kind;
          tag_nxt   = in_tuser;
          val_nxt   = dec_val;
          cnt_nxt   = dec_cnt;
          state_nxt = tvls_pkg::ST_TAG;
        end
      end
      tvls_pkg::ST_TAG: begin
        if (step_en) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = tag_r;
          out_last_nxt  = (kind_r == tvls_pkg::KIND_NONE);
          case (kind_r)
            tvls_pkg::KIND_INT: state_nxt = tvls_pkg::ST_LEB;
            tvls_pkg::KIND_RAW: state_nxt = tvls_pkg::ST_RAW;
            default:            state_nxt = tvls_pkg::ST_IDLE;
          endcase
        end
      end
      tvls_pkg::ST_LEB: begin
        if (step_en) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = leb_stop ? {1'b0, leb_grp} : (tvls_pkg::LEB_CONT_BIT | {1'b0, leb_grp});
          out_last_nxt  = leb_stop;
          val_nxt       = leb_rest;
          if (leb_stop) begin
            state_nxt = tvls_pkg::ST_IDLE;
          end
        end
      end
      tvls_pkg::ST_RAW: begin
        if (step_en) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = val_r[7:0];
          out_last_nxt  = (cnt_r == tvls_pkg::RAW_CNT_W'(1));
          val_nxt       = {8'h00, val_r[63:8]};
          cnt_nxt       = cnt_r - tvls_pkg::RAW_CNT_W'(1);
          if (cnt_r == tvls_pkg::RAW_CNT_W'(1)) begin
            state_nxt = tvls_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = tvls_pkg::ST_IDLE;
      end
    endcase
  end

  // A fresh request keeps the block busy for at least the tag byte.
  `TVLS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_tready,
                    "input accepted twice in a row")
  // The final LEB128 group returns the sequencer to idle and carries tlast.
  `TVLS_ASSERT_NEXT(a_leb_stop_last, clk, rst_n,
                    (state_r == tvls_pkg::ST_LEB) && step_en && leb_stop,
                    (state_r == tvls_pkg::ST_IDLE) && out_tvalid && out_tlast,
                    "LEB128 stop without end of value")
  // Raw byte countdown never runs dry while bytes remain to be sent.
  `TVLS_ASSERT_NOW(a_raw_cnt_live, clk, rst_n, state_r == tvls_pkg::ST_RAW,
                   cnt_r != '0, "raw byte counter underflow")

endmodule

// ===== dv/tvls_stream_checker.sv =====
// Scoreboard for the tagged value LEB128 serializer: it follows the tag code
// writes, predicts the byte stream for every accepted request and compares.
// Depends on tvls_pkg only.
`timescale 1ns / 100ps

module tvls_stream_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [63:0]                    in_tdata,   // [63:0] payload_bits
  input  logic [7:0]                     in_tuser,   // [7:0] type_tag
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [7:0]                     out_tdata,  // [7:0] out_byte
  input  logic                           out_tlast,  // end_of_value
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tvls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output int                             pending_bytes,
  output int                             fail_count
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } serial_byte_t;

  logic [7:0]   tag_codes [tvls_pkg::NUM_CODES];
  serial_byte_t expected_bytes [$];

  // Builds the whole byte stream of one value and queues it.
  function automatic void encode_value(input logic [7:0] tag, input logic [63:0] payload);
    logic [7:0]  stream [11];
    logic [63:0] value;
    logic [6:0]  grp;
    int          count;
    int          raw_count;
    bit          is_int;
    bit          done;
    count     = 1;
    stream[0] = tag;
    is_int    = 1'b1;
    raw_count = 0;
    done      = 1'b0;
    value     = payload;
    if (tag == tag_codes[tvls_pkg::REG_INT8])
      value = {{56{payload[7]}}, payload[7:0]};
    else if (tag == tag_codes[tvls_pkg::REG_INT16])
      value = {{48{payload[15]}}, payload[15:0]};
    else if (tag == tag_codes[tvls_pkg::REG_INT32])
      value = {{32{payload[31]}}, payload[31:0]};
    else if (tag == tag_codes[tvls_pkg::REG_INT64])
      value = payload;
    else begin
      is_int = 1'b0;
      if (tag == tag_codes[tvls_pkg::REG_FLOAT32])
        raw_count = int'(tvls_pkg::RAW_CNT_F32);
      else if (tag == tag_codes[tvls_pkg::REG_FLOAT64])
        raw_count = int'(tvls_pkg::RAW_CNT_F64);
    end

    if (is_int) begin
      while (!done) begin
        grp   = value[tvls_pkg::LEB_GROUP_W-1:0];
        value = {{tvls_pkg::LEB_GROUP_W{value[63]}}, value[63:tvls_pkg::LEB_GROUP_W]};
        // Stop once the rest is pure sign and the group's top bit agrees with it.
        if ((value == '0 && !grp[6]) || (value == '1 && grp[6])) begin
          stream[count] = {1'b0, grp};
          done = 1'b1;
        end else begin
          stream[count] = {1'b0, grp} | tvls_pkg::LEB_CONT_BIT;
        end
        count++;
      end
    end else begin
      for (int i = 0; i < raw_count; i++) begin
        stream[count] = payload[8*i +: 8];
        count++;
      end
    end

    for (int i = 0; i < count; i++)
      expected_bytes.push_back('{data: stream[i], last: (i == count - 1)});
  endfunction

  always @(posedge clk) begin
    serial_byte_t want;
    int           errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < tvls_pkg::NUM_CODES; i++)
        tag_codes[i] = tvls_pkg::CODE_RESET[i];
      expected_bytes.delete();
      pending_bytes <= 0;
      fail_count    <= 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < tvls_pkg::NUM_CODES)
        tag_codes[cfg_index] = cfg_data;

      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: byte %h (last %b) with no request outstanding",
                   $time, out_tdata, out_tlast);
          errs++;
        end else begin
          want = expected_bytes.pop_front();
          if (want.data !== out_tdata) begin
            $display("%0t: out_byte expected %h, got %h", $time, want.data, out_tdata);
            errs++;
          end
          if (want.last !== out_tlast) begin
            $display("%0t: end_of_value expected %b, got %b (byte %h)",
                     $time, want.last, out_tlast, out_tdata);
            errs++;
          end
        end
      end

      if (in_tvalid && in_tready)
        encode_value(in_tuser, in_tdata);

      fail_count    <= fail_count + errs;
      pending_bytes <= expected_bytes.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the tagged value LEB128 serializer: clock, reset, request
// and tag code stimulus, random back-pressure and the final verdict.
// Depends on tvls_pkg, the serializer top level and tvls_stream_checker.
`timescale 1ns / 100ps

module tb_top;

  // Margin for the output register to settle before touching the tag codes
  // or ending.
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int ITEMS_PER_PASS = 90;
  localparam int NUM_INDEXES    = 2 ** tvls_pkg::CFG_IDX_W;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [63:0]                    in_tdata;
  logic [7:0]                     in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [7:0]                     out_tdata;
  logic                           out_tlast;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [tvls_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                     cfg_data;

  int pending_bytes;
  int fail_count;

  // Percent chance that the sender pauses before a request, and that the
  // receiver drops out_tready in a given cycle.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Set by the stimulus to ask the receiver for one long stall.
  bit hold_off;

  // The tag codes as last written, used to aim random tags at known kinds.
  logic [7:0] codes [tvls_pkg::NUM_CODES];

  tagged_value_leb128_serializer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  tvls_stream_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending_bytes (pending_bytes),
    .fail_count    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops bytes.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Result side. Each cycle out_tready is drawn anew, except when the
  // stimulus asks for the long stall: then it is held low while the sender
  // keeps pushing, so the block fills up and must stall its own input.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one request and returns at the edge where it is taken. in_tvalid
  // stays high afterwards so that back-to-back requests need no gap; it is
  // only lowered when the sender decides to pause.
  task automatic send_value(input logic [7:0] tag, input logic [63:0] payload);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= tag;
    in_tdata  <= payload;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stops offering, waits for every predicted byte to come out, then lets the
  // block settle. The first edge makes the checker's count of the request
  // taken just now visible.
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes every index, the two unused ones included, from the codes array.
  // Writes to the unused indexes carry random data that must be dropped.
  task automatic write_codes;
    drain();
    for (int i = 0; i < NUM_INDEXES; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[tvls_pkg::CFG_IDX_W-1:0];
      cfg_data  <= (i < tvls_pkg::NUM_CODES) ? codes[i] : 8'($urandom);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Payloads that spread over every LEB128 length: a random word shifted
  // down by a random amount, possibly inverted to make it negative, mixed
  // with fully random words (which also put junk above the narrow widths)
  // and tiny values near zero.
  function automatic logic [63:0] random_payload;
    logic [63:0] word;
    word = {$urandom, $urandom};
    case ($urandom_range(3))
      0: random_payload = word;
      1: random_payload = word >> $urandom_range(63);
      2: random_payload = ~(word >> $urandom_range(63));
      default: random_payload = 64'($signed($urandom_range(130)) - 65);
    endcase
  endfunction

  // Most tags hit one of the current codes so the encoders get exercised;
  // the rest are arbitrary bytes, which are usually unknown tags.
  task automatic send_random(input int count);
    logic [7:0] tag;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 85)
        tag = codes[$urandom_range(tvls_pkg::NUM_CODES - 1)];
      else
        tag = 8'($urandom);
      send_value(tag, random_payload());
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    hold_off      = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 75;
    for (int i = 0; i < tvls_pkg::NUM_CODES; i++)
      codes[i] = tvls_pkg::CODE_RESET[i];

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed values under the reset codes. Narrow integers carry junk in
    // the upper payload bits, which must be ignored, and sit on the edges
    // where the LEB128 length changes.
    send_value(codes[tvls_pkg::REG_INT8],    64'hDEAD_BEEF_0000_007F);
    send_value(codes[tvls_pkg::REG_INT8],    64'h0123_4567_89AB_CD80);
    send_value(codes[tvls_pkg::REG_INT8],    64'hFFFF_FFFF_FFFF_FF3F);
    send_value(codes[tvls_pkg::REG_INT8],    64'h0000_0000_0000_0040);
    send_value(codes[tvls_pkg::REG_INT16],   64'hAAAA_AAAA_AAAA_8000);
    send_value(codes[tvls_pkg::REG_INT16],   64'h5555_5555_5555_7FFF);
    send_value(codes[tvls_pkg::REG_INT32],   64'hFFFF_FFFF_8000_0000);
    send_value(codes[tvls_pkg::REG_INT32],   64'h0000_0000_7FFF_FFFF);
    send_value(codes[tvls_pkg::REG_INT64],   64'h8000_0000_0000_0000);
    send_value(codes[tvls_pkg::REG_INT64],   64'h7FFF_FFFF_FFFF_FFFF);
    send_value(codes[tvls_pkg::REG_INT64],   64'hFFFF_FFFF_FFFF_FFFF);
    send_value(codes[tvls_pkg::REG_INT64],   64'h0000_0000_0000_0000);
    send_value(codes[tvls_pkg::REG_INT64],   64'hFFFF_FFFF_FFFF_FFC0);
    send_value(codes[tvls_pkg::REG_INT64],   64'hFFFF_FFFF_FFFF_FFBF);
    // Float32 must drop the upper word; float64 sends all eight bytes.
    send_value(codes[tvls_pkg::REG_FLOAT32], 64'hCAFE_F00D_3F80_0000);
    send_value(codes[tvls_pkg::REG_FLOAT64], 64'h0102_0304_0506_0708);
    send_value(codes[tvls_pkg::REG_FLOAT64], 64'hFFFF_FFFF_FFFF_FFFF);
    // Unknown tags produce the tag byte alone.
    send_value(8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    send_value(8'hFF, 64'h1234_5678_9ABC_DEF0);
    send_value(8'h01, 64'h0000_0000_0000_0000);

    // Sender idles a little, receiver a lot.
    send_random(ITEMS_PER_PASS);

    // Extreme and unusual codes; tag 0 and tag 255 become integer kinds.
    codes = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA};
    write_codes();
    send_idle_pct = 75;
    recv_idle_pct = 16;
    send_value(8'h00, 64'h0000_0000_0000_00C0);
    send_value(8'hFF, 64'h0000_0000_0000_2000);
    send_random(ITEMS_PER_PASS);

    // Overlapping codes: the earlier register in the priority order must win.
    codes = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h01};
    write_codes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // The receiver stalls for a long stretch while requests keep coming.
    hold_off = 1'b1;
    send_value(8'hFF, 64'h0000_0000_0000_FF80);
    send_value(8'h00, 64'h8000_0000_8000_0000);
    send_value(8'h01, 64'h1122_3344_5566_7788);
    send_random(ITEMS_PER_PASS);

    // Back near the reset codes, with int64 shadowing float32.
    codes = '{8'h02, 8'h03, 8'h04, 8'h05, 8'h05, 8'h07};
    write_codes();
    send_random(ITEMS_PER_PASS);

    drain();
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
